// File: hw/rtl/lfo_wg_pkg.sv
// ----------------------------------------------------------------------------
// lfo_wg_pkg
// Shared widths, waveform codes, stage item types and the quarter-wave sine
// entry function for the LFO waveform generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lfo_wg_pkg;

  // Field widths
  localparam int PLAYHEAD_W = 32;
  localparam int SPEED_W    = 24;
  localparam int WAVE_W     = 3;
  localparam int PHASE_W    = 16;
  localparam int LEVEL_W    = 17;
  localparam int FRAC_W     = 32;
  localparam int PRODUCT_W  = PLAYHEAD_W + SPEED_W;

  // Waveform codes
  localparam logic [WAVE_W-1:0] WAVE_RAMP     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd3;
  localparam logic [WAVE_W-1:0] WAVE_PULSE    = 3'd4;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd5;

  // Q1.16 levels
  localparam logic [LEVEL_W-1:0] ONE_Q16  = 17'h10000;
  localparam logic [LEVEL_W-1:0] HALF_Q16 = 17'h08000;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Phase stage item
  typedef struct packed {
    logic [PHASE_W-1:0] f16;
    logic [WAVE_W-1:0]  waveform;
    logic [PHASE_W-1:0] pulse_width;
    logic               offset_enable;
    logic [PHASE_W-1:0] output_offset;
  } phase_item_t;

  // Shape stage item
  typedef struct packed {
    logic [LEVEL_W-1:0] base_level;
    logic               is_sine;
    logic               sine_low;
    logic [PHASE_W-1:0] half_sine;
    logic               offset_enable;
    logic [PHASE_W-1:0] output_offset;
  } shape_item_t;

  // Entry idx of the quarter-wave table of 0.5*sin in Q0.16, rounded to
  // nearest, for a table of 2**qbits steps. Evaluated at elaboration only.
  function automatic logic [PHASE_W-1:0] half_sine_entry(int unsigned idx,
                                                          int unsigned qbits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned h;
    longint          sum;
    x    = (HALF_PI_Q30 * longint'(idx) + (64'd1 << (qbits - 1))) >> qbits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    // Taylor series, alternating terms
    term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 342; sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    h = (longint'(sum) + 64'd16384) >> 15;
    if (h > 64'd32768) begin
      h = 64'd32768;
    end
    return h[PHASE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lfo_wg_if.sv
// ----------------------------------------------------------------------------
// lfo_wg_if
// Valid/ready channels of the LFO waveform generator: the sample request
// channel and the level result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfo_wg_in_if;
  import lfo_wg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PLAYHEAD_W-1:0] playhead;
  logic [SPEED_W-1:0]    speed;
  logic [WAVE_W-1:0]     waveform;
  logic [PHASE_W-1:0]    pulse_width;
  logic                  offset_enable;
  logic [PHASE_W-1:0]    output_offset;

  modport source (
    output valid, playhead, speed, waveform, pulse_width, offset_enable,
           output_offset,
    input  ready
  );

  modport sink (
    input  valid, playhead, speed, waveform, pulse_width, offset_enable,
           output_offset,
    output ready
  );
endinterface

interface lfo_wg_out_if;
  import lfo_wg_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (
    output valid, level,
    input  ready
  );

  modport sink (
    input  valid, level,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/lfo_wg_phase.sv
// ----------------------------------------------------------------------------
// lfo_wg_phase
// Input stage: multiplies playhead by speed, keeps the fraction of the
// product as a 16-bit phase and registers it with the rest of the item.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_wg_phase #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  lfo_wg_in_if.sink                in_ch,
  output logic                     phs_valid,
  input  logic                     phs_ready,
  output lfo_wg_pkg::phase_item_t  phs_item
);
  import lfo_wg_pkg::*;

  // Low phase bits that a short fraction leaves at zero
  localparam int ZERO_BITS = (FRACTION_BITS < PHASE_W) ? PHASE_W - FRACTION_BITS : 0;
  localparam logic [PHASE_W-1:0] PHASE_MASK = PHASE_W'({PHASE_W{1'b1}} << ZERO_BITS);

  logic [PRODUCT_W-1:0] product;
  logic                 advance;
  logic                 valid_r;
  phase_item_t          item_r;
  phase_item_t          item_nxt;

  // Stage is free when empty or when its item moves on
  assign advance     = !valid_r || phs_ready;
  assign in_ch.ready = advance;

  // Form the phase from the fractional part of the product
  assign product = {{SPEED_W{1'b0}}, in_ch.playhead} *
                   {{PLAYHEAD_W{1'b0}}, in_ch.speed};

  always_comb begin
    item_nxt.f16           = product[FRAC_W-1 -: PHASE_W] & PHASE_MASK;
    item_nxt.waveform      = in_ch.waveform;
    item_nxt.pulse_width   = in_ch.pulse_width;
    item_nxt.offset_enable = in_ch.offset_enable;
    item_nxt.output_offset = in_ch.output_offset;
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_ch.valid;
    end
  end

  // Load the item
  always_ff @(posedge clk) begin
    if (advance && in_ch.valid) begin
      item_r <= item_nxt;
    end
  end

  assign phs_valid = valid_r;
  assign phs_item  = item_r;

endmodule

`default_nettype wire

// File: hw/rtl/lfo_wg_shape.sv
// ----------------------------------------------------------------------------
// lfo_wg_shape
// Shape stage: forms the level of the non-sine waveforms and reads the
// quarter-wave sine table at the mirrored phase index.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_wg_shape #(
  parameter int SINE_PHASE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     phs_valid,
  output logic                     phs_ready,
  input  lfo_wg_pkg::phase_item_t  phs_item,
  output logic                     shp_valid,
  input  logic                     shp_ready,
  output lfo_wg_pkg::shape_item_t  shp_item
);
  import lfo_wg_pkg::*;

  localparam int QBITS       = SINE_PHASE_BITS - 2;
  localparam int QUARTER_LEN = 1 << QBITS;
  localparam int ADDR_W      = SINE_PHASE_BITS - 1;

  logic [PHASE_W-1:0]         sine_rom [QUARTER_LEN+1];
  logic [SINE_PHASE_BITS-1:0] sine_phase;
  logic [1:0]                 quad;
  logic [QBITS-1:0]           quarter_idx;
  logic [ADDR_W-1:0]          rom_addr;
  logic [LEVEL_W-1:0]         twice_f;
  logic                       advance;
  logic                       valid_r;
  shape_item_t                item_r;
  shape_item_t                item_nxt;

  // Quarter-wave table, fixed at elaboration
  for (genvar g = 0; g <= QUARTER_LEN; g++) begin : g_rom
    assign sine_rom[g] = half_sine_entry(g, QBITS);
  end

  assign advance   = !valid_r || shp_ready;
  assign phs_ready = advance;

  // Split the sine phase into quadrant and index; mirror odd quadrants
  assign sine_phase  = phs_item.f16[PHASE_W-1 -: SINE_PHASE_BITS];
  assign quad        = sine_phase[SINE_PHASE_BITS-1 -: 2];
  assign quarter_idx = sine_phase[QBITS-1:0];
  assign rom_addr    = quad[0] ? ADDR_W'(QUARTER_LEN) - ADDR_W'(quarter_idx)
                               : ADDR_W'(quarter_idx);

  assign twice_f = {phs_item.f16, 1'b0};

  // Select the base level by waveform
  always_comb begin
    item_nxt.is_sine       = 1'b0;
    item_nxt.sine_low      = quad[1];
    item_nxt.half_sine     = sine_rom[rom_addr];
    item_nxt.offset_enable = phs_item.offset_enable;
    item_nxt.output_offset = phs_item.output_offset;
    case (phs_item.waveform)
      WAVE_RAMP: begin
        item_nxt.base_level = {1'b0, phs_item.f16};
      end
      WAVE_TRIANGLE: begin
        item_nxt.base_level = twice_f[PHASE_W] ? {1'b0, twice_f[PHASE_W-1:0]}
                                               : ONE_Q16 - twice_f;
      end
      WAVE_SAW: begin
        item_nxt.base_level = ONE_Q16 - {1'b0, phs_item.f16};
      end
      WAVE_SINE: begin
        item_nxt.base_level = '0;
        item_nxt.is_sine    = 1'b1;
      end
      WAVE_PULSE: begin
        item_nxt.base_level = (phs_item.f16 < phs_item.pulse_width) ? ONE_Q16 : '0;
      end
      WAVE_SQUARE: begin
        item_nxt.base_level = phs_item.f16[PHASE_W-1] ? '0 : ONE_Q16;
      end
      default: begin
        item_nxt.base_level = '0;
      end
    endcase
  end

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= phs_valid;
    end
  end

  // Load the item, table read included
  always_ff @(posedge clk) begin
    if (advance && phs_valid) begin
      item_r <= item_nxt;
    end
  end

  assign shp_valid = valid_r;
  assign shp_item  = item_r;

endmodule

`default_nettype wire

// File: hw/rtl/lfo_wg_mix.sv
// ----------------------------------------------------------------------------
// lfo_wg_mix
// Output stage: completes the sine level, applies the optional offset with
// wrap at 1.0 and holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_wg_mix (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shp_valid,
  output logic                     shp_ready,
  input  lfo_wg_pkg::shape_item_t  shp_item,
  lfo_wg_out_if.source             out_ch
);
  import lfo_wg_pkg::*;

  logic [LEVEL_W-1:0] wave_level;
  logic [LEVEL_W-1:0] offset_sum;
  logic [LEVEL_W-1:0] level_nxt;
  logic [LEVEL_W-1:0] level_r;
  logic               advance;
  logic               valid_r;

  assign advance   = !valid_r || out_ch.ready;
  assign shp_ready = advance;

  // Fold the table value around one half
  always_comb begin
    if (shp_item.is_sine) begin
      wave_level = shp_item.sine_low ? HALF_Q16 - {1'b0, shp_item.half_sine}
                                     : HALF_Q16 + {1'b0, shp_item.half_sine};
    end else begin
      wave_level = shp_item.base_level;
    end
  end

  // Add the offset; the sum stays below 2.0, so wrapping drops bit 16
  assign offset_sum = wave_level + {1'b0, shp_item.output_offset};
  assign level_nxt  = shp_item.offset_enable ? {1'b0, offset_sum[PHASE_W-1:0]}
                                             : wave_level;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= shp_valid;
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (advance && shp_valid) begin
      level_r <= level_nxt;
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.level = level_r;

endmodule

`default_nettype wire

// File: hw/rtl/lfo_waveform_generator.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// LFO sample generator: one Q1.16 level for each playhead/speed request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one request item: playhead (Q16.16), speed (Q8.16),
//          waveform code, pulse width, offset enable and output offset.
//   out_ch carries one level item (Q1.16, 65536 is 1.0) per request, in
//          request order.
//   Both are valid/ready channels; an item moves when valid and ready are
//   high at a rising edge.
//   From acceptance to out_ch.valid an item passes the multiplier stage,
//   the shape stage with the sine table read, and the output stage.
//   Throughput is one item per cycle while out_ch.ready is high; a stage
//   takes an item when free; the 32x24 multiplier sets the longest path.
//   A synchronous active-low reset empties all three stages; there is no
//   table to clear and the block accepts items right after reset.
//   When the receiver stalls, the result holds in the output register and
//   the stages behind it keep filling; in_ch.ready drops only once all
//   three stages hold an item.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_waveform_generator #(
  parameter int SINE_PHASE_BITS = 10,
  parameter int FRACTION_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  lfo_wg_in_if.sink    in_ch,
  lfo_wg_out_if.source out_ch
);
  import lfo_wg_pkg::*;

  logic        phs_valid;
  logic        phs_ready;
  phase_item_t phs_item;
  logic        shp_valid;
  logic        shp_ready;
  shape_item_t shp_item;

  // Phase from the product
  lfo_wg_phase #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_phase (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .phs_valid (phs_valid),
    .phs_ready (phs_ready),
    .phs_item  (phs_item)
  );

  // Waveform shape and sine table
  lfo_wg_shape #(
    .SINE_PHASE_BITS (SINE_PHASE_BITS)
  ) u_shape (
    .clk       (clk),
    .rst_n     (rst_n),
    .phs_valid (phs_valid),
    .phs_ready (phs_ready),
    .phs_item  (phs_item),
    .shp_valid (shp_valid),
    .shp_ready (shp_ready),
    .shp_item  (shp_item)
  );

  // Offset and result register
  lfo_wg_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .shp_valid (shp_valid),
    .shp_ready (shp_ready),
    .shp_item  (shp_item),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  // An accepted item always lands in the phase stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> phs_valid)
    else $error("accepted item missing from phase stage");

  // A shape item with a free output stage reaches the output
  a_shape_moves: assert property (@(posedge clk) disable iff (!rst_n)
    shp_valid && (!out_ch.valid || out_ch.ready) |=> out_ch.valid)
    else $error("shape item lost on the way to the output");

  // Input back-pressure only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> phs_valid && shp_valid && out_ch.valid)
    else $error("input stalled with a free stage");

  // A level never exceeds 1.0
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.level <= ONE_Q16)
    else $error("level above 1.0");
`endif

endmodule

`default_nettype wire

// File: tb/lfo_waveform_generator_checker.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator_checker
// Watches both channels of the LFO waveform generator. It computes the level
// for every request item the block takes in, queues it, and compares every
// level item that leaves the block against the oldest queued level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_waveform_generator_checker #(
  parameter int SINE_PHASE_BITS = 10,
  parameter int FRACTION_BITS   = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  lfo_wg_in_if  in_mon,
  lfo_wg_out_if out_mon,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lfo_wg_pkg::*;

  localparam int QUARTER_STEPS = 1 << (SINE_PHASE_BITS - 2);

  logic [PHASE_W-1:0] quarter_sine [0:QUARTER_STEPS];
  logic [LEVEL_W-1:0] level_q [$];

  // 0.5*sin of step*(pi/2)/QUARTER_STEPS in Q0.16, from a Q30 Taylor series
  function automatic logic [PHASE_W-1:0] half_sine_at(int unsigned step);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    int unsigned     k;
    angle    = (HALF_PI_Q30 * 64'(step) + 64'(QUARTER_STEPS / 2)) / 64'(QUARTER_STEPS);
    angle_sq = (angle * angle) >> 30;
    term     = angle;
    acc      = longint'(angle);
    for (k = 1; k <= 9; k++) begin
      term = ((term * angle_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = (acc + 64'd16384) >> 15;
    if (rounded > 64'd32768) begin
      rounded = 64'd32768;
    end
    return rounded[PHASE_W-1:0];
  endfunction

  // Fraction of playhead*speed, cut to FRACTION_BITS and brought to Q0.16
  function automatic logic [PHASE_W-1:0] phase_of(logic [PLAYHEAD_W-1:0] playhead,
                                                   logic [SPEED_W-1:0] speed);
    longint unsigned product;
    longint unsigned frac;
    product = 64'(playhead) * 64'(speed);
    frac    = (product >> (32 - FRACTION_BITS)) & ((64'd1 << FRACTION_BITS) - 64'd1);
    if (FRACTION_BITS >= PHASE_W) begin
      frac = frac >> (FRACTION_BITS - PHASE_W);
    end else begin
      frac = frac << (PHASE_W - FRACTION_BITS);
    end
    return frac[PHASE_W-1:0];
  endfunction

  // Level of one request item, Q1.16
  function automatic logic [LEVEL_W-1:0] level_of(logic [PLAYHEAD_W-1:0] playhead,
                                                   logic [SPEED_W-1:0]    speed,
                                                   logic [WAVE_W-1:0]     waveform,
                                                   logic [PHASE_W-1:0]    pulse_width,
                                                   logic                  offset_enable,
                                                   logic [PHASE_W-1:0]    output_offset);
    logic [PHASE_W-1:0]         f;
    logic [LEVEL_W-1:0]         twice;
    logic [LEVEL_W-1:0]         lvl;
    logic [SINE_PHASE_BITS-1:0] sine_phase;
    logic [1:0]                 quad;
    int unsigned                idx;
    logic [PHASE_W-1:0]         half;
    logic [LEVEL_W:0]           sum;
    f     = phase_of(playhead, speed);
    twice = {f, 1'b0};
    case (waveform)
      WAVE_RAMP: begin
        lvl = {1'b0, f};
      end
      WAVE_TRIANGLE: begin
        lvl = (twice >= ONE_Q16) ? twice - ONE_Q16 : ONE_Q16 - twice;
      end
      WAVE_SAW: begin
        lvl = ONE_Q16 - {1'b0, f};
      end
      WAVE_SINE: begin
        // mirror the quarter table on odd quadrants, flip it on the lower half
        sine_phase = f[PHASE_W-1 -: SINE_PHASE_BITS];
        quad       = sine_phase[SINE_PHASE_BITS-1 -: 2];
        idx        = 32'(sine_phase[SINE_PHASE_BITS-3:0]);
        half       = quad[0] ? quarter_sine[QUARTER_STEPS - idx] : quarter_sine[idx];
        lvl        = quad[1] ? HALF_Q16 - {1'b0, half} : HALF_Q16 + {1'b0, half};
      end
      WAVE_PULSE: begin
        lvl = (f < pulse_width) ? ONE_Q16 : '0;
      end
      WAVE_SQUARE: begin
        lvl = ({1'b0, f} < HALF_Q16) ? ONE_Q16 : '0;
      end
      default: begin
        lvl = '0;
      end
    endcase
    // add the offset and wrap at 1.0
    if (offset_enable) begin
      sum = {1'b0, lvl} + {2'b00, output_offset};
      if (sum >= {1'b0, ONE_Q16}) begin
        sum = sum - {1'b0, ONE_Q16};
      end
      lvl = sum[LEVEL_W-1:0];
    end
    return lvl;
  endfunction

  initial begin
    for (int unsigned i = 0; i <= QUARTER_STEPS; i++) begin
      quarter_sine[i] = half_sine_at(i);
    end
  end

  // Compare leaving levels, then queue the level of each accepted request
  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    int                 errs;
    if (!rst_n) begin
      level_q.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      errs = fail_count;
      if (out_mon.valid && out_mon.ready) begin
        if (level_q.size() == 0) begin
          $display("%0t: level item %0d with no request outstanding", $time, out_mon.level);
          errs++;
        end else begin
          want = level_q.pop_front();
          if (out_mon.level !== want) begin
            $display("%0t: level mismatch, expected %0d, actual %0d",
                     $time, want, out_mon.level);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        level_q.push_back(level_of(in_mon.playhead, in_mon.speed, in_mon.waveform,
                                   in_mon.pulse_width, in_mon.offset_enable,
                                   in_mon.output_offset));
      end
      fail_count <= errs;
      pending    <= level_q.size();
    end
  end

endmodule

`default_nettype wire

// File: tb/lfo_waveform_generator_tb.sv
// ----------------------------------------------------------------------------
// lfo_waveform_generator_tb
// Drives request items into the LFO waveform generator: a directed set over
// all waveform codes, phase extremes, sine quadrant edges, pulse widths and
// offset wrap, then random items in bursts. The receiver stalls on its own
// pattern and once holds off long enough to back the block up. The checker
// beside the block does all comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module lfo_waveform_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfo_wg_pkg::*;

  localparam int SINE_BITS       = 10;
  localparam int FRAC_BITS       = 16;
  localparam int RANDOM_ITEMS    = 400;
  localparam int SQUEEZE_AT      = 150;
  localparam int SQUEEZE_ITEMS   = 24;
  localparam int PAUSE_AT        = 300;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int TAIL_CYCLES     = 8;
  localparam int CYCLE_LIMIT     = 200000;

  // codes past the square wave give a zero base level
  localparam logic [WAVE_W-1:0] WAVE_SPARE_LO = 3'd6;
  localparam logic [WAVE_W-1:0] WAVE_SPARE_HI = 3'd7;

  localparam logic [PLAYHEAD_W-1:0] PLAYHEAD_ONE = 32'h0001_0000;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   hold_off_asked;
  int   cycles = 0;

  lfo_wg_in_if  in_ch ();
  lfo_wg_out_if out_ch ();

  lfo_waveform_generator #(
    .SINE_PHASE_BITS(SINE_BITS),
    .FRACTION_BITS  (FRAC_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  lfo_waveform_generator_checker #(
    .SINE_PHASE_BITS(SINE_BITS),
    .FRACTION_BITS  (FRAC_BITS)
  ) u_level_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // End the run if it hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lfo_waveform_generator regression: fail");
      $finish;
    end
  end

  // Offer one request item and hold it until the block takes it
  task automatic send_req(logic [PLAYHEAD_W-1:0] playhead, logic [SPEED_W-1:0] speed,
                          logic [WAVE_W-1:0] waveform, logic [PHASE_W-1:0] pulse_width,
                          logic offset_enable, logic [PHASE_W-1:0] output_offset);
    in_ch.valid         <= 1'b1;
    in_ch.playhead      <= playhead;
    in_ch.speed         <= speed;
    in_ch.waveform      <= waveform;
    in_ch.pulse_width   <= pulse_width;
    in_ch.offset_enable <= offset_enable;
    in_ch.output_offset <= output_offset;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_sender(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering until every level has come back
  task automatic wait_for_levels();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Random request, biased toward integer playheads, slow speeds and edges
  task automatic send_random_req();
    logic [PLAYHEAD_W-1:0] playhead;
    logic [SPEED_W-1:0]    speed;
    logic [WAVE_W-1:0]     waveform;
    logic [PHASE_W-1:0]    pulse_width;
    case ($urandom_range(0, 3))
      0:       playhead = $urandom;
      1:       playhead = $urandom << 16;
      2:       playhead = $urandom_range(0, 32'h0001_FFFF);
      default: playhead = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
    endcase
    case ($urandom_range(0, 2))
      0:       speed = SPEED_W'($urandom);
      1:       speed = SPEED_W'($urandom_range(0, 16'hFFFF));
      default: speed = SPEED_W'($urandom_range(24'hF0_0000, 24'hFF_FFFF));
    endcase
    if ($urandom_range(0, 15) == 0) begin
      waveform = WAVE_W'($urandom_range(WAVE_SPARE_LO, WAVE_SPARE_HI));
    end else begin
      waveform = WAVE_W'($urandom_range(WAVE_RAMP, WAVE_SQUARE));
    end
    case ($urandom_range(0, 9))
      0:       pulse_width = '0;
      1:       pulse_width = '1;
      default: pulse_width = PHASE_W'($urandom);
    endcase
    send_req(playhead, speed, waveform, pulse_width, 1'($urandom_range(0, 1)),
             PHASE_W'($urandom));
  endtask

  // Stimulus
  initial begin
    int  sent;
    int  burst;
    bit  squeezed;
    bit  paused;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.playhead      <= '0;
    in_ch.speed         <= '0;
    in_ch.waveform      <= WAVE_RAMP;
    in_ch.pulse_width   <= '0;
    in_ch.offset_enable <= 1'b0;
    in_ch.output_offset <= '0;
    hold_off_asked      <= 0;
    sent     = 0;
    squeezed = 1'b0;
    paused   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero phase on every code, zero pulse width included
    for (int w = int'(WAVE_RAMP); w <= int'(WAVE_SPARE_HI); w++) begin
      send_req('0, '0, WAVE_W'(w), '0, 1'b0, '0);
    end
    // all fields at their maximum, offset on
    for (int w = int'(WAVE_RAMP); w <= int'(WAVE_SPARE_HI); w++) begin
      send_req('1, '1, WAVE_W'(w), '1, 1'b1, '1);
    end
    // sine at the quadrant edges; with a unit playhead the phase is the speed
    send_req(PLAYHEAD_ONE, 24'h00_4000, WAVE_SINE, '0, 1'b0, '0);
    send_req(PLAYHEAD_ONE, 24'h00_8000, WAVE_SINE, '0, 1'b0, '0);
    send_req(PLAYHEAD_ONE, 24'h00_C000, WAVE_SINE, '0, 1'b0, '0);
    send_req(PLAYHEAD_ONE, 24'h00_FFFF, WAVE_SINE, '0, 1'b0, '0);
    // zero pulse width mid-cycle, full width at the last phase step
    send_req(PLAYHEAD_ONE, 24'h00_1234, WAVE_PULSE, '0, 1'b0, '0);
    send_req(PLAYHEAD_ONE, 24'h00_FFFF, WAVE_PULSE, '1, 1'b0, '0);
    // ramp with an offset that wraps to exactly zero
    send_req(PLAYHEAD_ONE, 24'h00_C000, WAVE_RAMP, '0, 1'b1, 16'h4000);
    wait_for_levels();

    // random bursts with random gaps
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_random_req();
        sent++;
      end
      // keep offering while the receiver holds off
      if (!squeezed && sent >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold_off_asked <= hold_off_asked + 1;
        repeat (SQUEEZE_ITEMS) send_random_req();
        sent += SQUEEZE_ITEMS;
      end
      if (!paused && sent >= PAUSE_AT) begin
        paused = 1'b1;
        wait_for_levels();
      end
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end

    wait_for_levels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("lfo_waveform_generator regression: pass");
    end else begin
      $display("lfo_waveform_generator regression: fail");
    end
    $finish;
  end

  // Receiver: stretches of free flow, random stalls and a fixed stall mask
  initial begin
    int          span;
    int          density;
    int          given;
    rx_mode_t    mode;
    logic [7:0]  mask;
    out_ch.ready <= 1'b0;
    given = 0;
    @(posedge clk);
    forever begin
      span    = $urandom_range(16, 96);
      mode    = rx_mode_t'($urandom_range(RX_FREE, RX_PATTERN));
      density = $urandom_range(1, 3);
      mask    = 8'($urandom) | 8'h01;
      for (int i = 0; i < span; i++) begin
        // hold off long enough for the block to fill and stall its input
        if (hold_off_asked > given) begin
          given++;
          out_ch.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
        end
        case (mode)
          RX_FREE:   out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) < density);
          default:   out_ch.ready <= mask[i % 8];
        endcase
        @(posedge clk);
      end
    end
  end

endmodule

`default_nettype wire
